/* rtl/sat_pkg.sv */
package sat_pkg;

    // Default width of the argument counter
    localparam int COUNT_BITS_DEF = 8;

    // Character codes the parser reacts to
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // Largest count shown on the result
    localparam logic [7:0] SHOWN_MAX = 8'hFF;

    // Parser states
    typedef enum logic [2:0] {
        ST_BETWEEN = 3'd0,
        ST_IN_ARG  = 3'd1,
        ST_ESC     = 3'd2,
        ST_SQ      = 3'd3,
        ST_DQ      = 3'd4,
        ST_SQ_ESC  = 3'd5,
        ST_DQ_ESC  = 3'd6
    } t_state;

    // Input beat
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       arg_start;
        logic       arg_end;
        logic [7:0] arg_count;
        logic       line_done;
    } t_out_beat;

endpackage

/* rtl/sat_step.sv */
module sat_step #(
    parameter int COUNT_BITS = sat_pkg::COUNT_BITS_DEF
) (
    input  sat_pkg::t_state    i_state,
    input  logic [COUNT_BITS-1:0] i_args,
    input  sat_pkg::t_in_beat  i_beat,
    output sat_pkg::t_state    o_state,
    output logic [COUNT_BITS-1:0] o_args,
    output sat_pkg::t_out_beat o_beat
);

    localparam int WIDE = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] ARGS_MAX = {COUNT_BITS{1'b1}};

    sat_pkg::t_state nx;
    logic keep;
    logic is_sep;
    logic open_before;
    logic start;
    logic stop;
    logic [COUNT_BITS-1:0] args_inc;
    logic [WIDE-1:0] shown_wide;
    logic [7:0] shown;

    assign is_sep = (i_beat.ch == sat_pkg::CH_SPACE) || (i_beat.ch == sat_pkg::CH_TAB);
    assign open_before = (i_state != sat_pkg::ST_BETWEEN) && (i_state != 3'd7);

    // Next state for a character beat
    always_comb begin
        nx = i_state;
        unique case (i_state)
            sat_pkg::ST_ESC: begin
                nx = sat_pkg::ST_IN_ARG;
            end
            sat_pkg::ST_SQ: begin
                if (i_beat.ch == sat_pkg::CH_BSLASH) begin
                    nx = sat_pkg::ST_SQ_ESC;
                end else if (i_beat.ch == sat_pkg::CH_SQUOTE) begin
                    nx = sat_pkg::ST_IN_ARG;
                end
            end
            sat_pkg::ST_DQ: begin
                if (i_beat.ch == sat_pkg::CH_BSLASH) begin
                    nx = sat_pkg::ST_DQ_ESC;
                end else if (i_beat.ch == sat_pkg::CH_DQUOTE) begin
                    nx = sat_pkg::ST_IN_ARG;
                end
            end
            sat_pkg::ST_SQ_ESC: begin
                nx = sat_pkg::ST_SQ;
            end
            sat_pkg::ST_DQ_ESC: begin
                nx = sat_pkg::ST_DQ;
            end
            default: begin
                // between arguments, inside one, or the unused code
                if (is_sep) begin
                    nx = sat_pkg::ST_BETWEEN;
                end else if (i_beat.ch == sat_pkg::CH_BSLASH) begin
                    nx = sat_pkg::ST_ESC;
                end else if (i_beat.ch == sat_pkg::CH_SQUOTE) begin
                    nx = sat_pkg::ST_SQ;
                end else if (i_beat.ch == sat_pkg::CH_DQUOTE) begin
                    nx = sat_pkg::ST_DQ;
                end else begin
                    nx = sat_pkg::ST_IN_ARG;
                end
            end
        endcase
    end

    // Whether the byte is kept in the argument
    always_comb begin
        keep = 1'b0;
        unique case (i_state)
            sat_pkg::ST_ESC, sat_pkg::ST_SQ_ESC, sat_pkg::ST_DQ_ESC: begin
                keep = 1'b1;
            end
            sat_pkg::ST_SQ: begin
                keep = (i_beat.ch != sat_pkg::CH_BSLASH) && (i_beat.ch != sat_pkg::CH_SQUOTE);
            end
            sat_pkg::ST_DQ: begin
                keep = (i_beat.ch != sat_pkg::CH_BSLASH) && (i_beat.ch != sat_pkg::CH_DQUOTE);
            end
            default: begin
                keep = !is_sep && (i_beat.ch != sat_pkg::CH_BSLASH)
                    && (i_beat.ch != sat_pkg::CH_SQUOTE) && (i_beat.ch != sat_pkg::CH_DQUOTE);
            end
        endcase
    end

    assign start = !open_before && (nx != sat_pkg::ST_BETWEEN);
    assign stop  = open_before && (nx == sat_pkg::ST_BETWEEN);

    // Saturating argument count
    assign args_inc = (start && (i_args != ARGS_MAX)) ? i_args + 1'b1 : i_args;

    // Shown count: after this beat for characters, as is at end of line
    assign shown_wide = i_beat.end_of_line ? WIDE'(i_args) : WIDE'(args_inc);
    assign shown = (shown_wide > WIDE'(sat_pkg::SHOWN_MAX)) ? sat_pkg::SHOWN_MAX
                                                            : shown_wide[7:0];

    // End of line closes everything and returns to reset values
    always_comb begin
        o_beat.arg_count = shown;
        if (i_beat.end_of_line) begin
            o_state           = sat_pkg::ST_BETWEEN;
            o_args            = '0;
            o_beat.out_char   = 8'h00;
            o_beat.char_valid = 1'b0;
            o_beat.arg_start  = 1'b0;
            o_beat.arg_end    = open_before;
            o_beat.line_done  = 1'b1;
        end else begin
            o_state           = nx;
            o_args            = args_inc;
            o_beat.out_char   = keep ? i_beat.ch : 8'h00;
            o_beat.char_valid = keep;
            o_beat.arg_start  = start;
            o_beat.arg_end    = stop;
            o_beat.line_done  = 1'b0;
        end
    end

endmodule

/* rtl/shell_argument_tokenizer_top.sv */
// Shell argument tokenizer.
// Input channel (i_in_valid / o_in_ready / i_in_data): one byte of a command
// line per beat, or an end-of-line beat that closes any open argument and
// returns the parser to its reset state.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
// beat per input beat, in order: the kept byte, argument start/end flags,
// the running argument count and a line-done flag.
// The accepting edge loads the input register; the beat then moves through
// the parser logic into the result register once that register is free.
// Throughput is one beat per cycle while the receiver does not stall; the
// parse state and counter are updated in the same cycle the beat moves
// into the result register.
// When the receiver stalls, the result register holds and the input
// register still takes one more beat; after that o_in_ready drops until the
// result drains. Reset (i_rst_n low, synchronous) empties both registers,
// sets the parser between arguments and clears the argument count.
module shell_argument_tokenizer_top #(
    parameter int COUNT_BITS = sat_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sat_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sat_pkg::t_out_beat o_out_data
);

    logic                  r_in_valid;
    sat_pkg::t_in_beat     r_in;
    logic                  r_out_valid;
    sat_pkg::t_out_beat    r_out;
    sat_pkg::t_state       r_state;
    logic [COUNT_BITS-1:0] r_args;

    sat_pkg::t_state       n_state;
    logic [COUNT_BITS-1:0] n_args;
    sat_pkg::t_out_beat    n_out;

    logic out_free;
    logic adv;

    // Handshake: result register frees when empty or taken
    assign out_free   = !r_out_valid || i_out_ready;
    assign adv        = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    sat_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .i_state (r_state),
        .i_args  (r_args),
        .i_beat  (r_in),
        .o_state (n_state),
        .o_args  (n_args),
        .o_beat  (n_out)
    );

    // Control and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= sat_pkg::ST_BETWEEN;
            r_args      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (adv) begin
                r_state <= n_state;
                r_args  <= n_args;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/sat_chk.sv */
module sat_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input sat_pkg::t_out_beat o_out_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // Reset empties the output side
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // End-of-line results carry no byte and start nothing
    a_eol_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.line_done |->
            !o_out_data.char_valid && !o_out_data.arg_start
            && (o_out_data.out_char == 8'h00))
        else $error("end-of-line result malformed");

    // A dropped byte reads as zero
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.char_valid |-> o_out_data.out_char == 8'h00)
        else $error("byte shown without char_valid");

    // A started argument is counted and does not also end on that beat
    a_start_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.arg_start |->
            (o_out_data.arg_count != 8'h00) && !o_out_data.arg_end)
        else $error("argument start without count");

endmodule

bind shell_argument_tokenizer_top sat_chk u_sat_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
